>>> design/breakpoint_ramp_interpolator_top_assert.svh
// Assertion macros for the breakpoint ramp interpolator.
// Define NO_ASSERTIONS to compile them out.
`ifndef BREAKPOINT_RAMP_INTERPOLATOR_TOP_ASSERT_SVH
`define BREAKPOINT_RAMP_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BRK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BRK_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BRK_ASSERT(name, prop, msg)
`define BRK_ASSERT_NEVER(name, cond, msg)
`endif

`endif

>>> design/brk_pkg.sv
package brk_pkg;

  localparam int unsigned MaxKnots = 16;
  localparam int unsigned KnotAw   = $clog2(MaxKnots);
  localparam int unsigned CountW   = 5;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned RefusalW = 16;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned ProdW    = FrameW + ValueW + 1;
  localparam int unsigned MagW     = ProdW - 1;
  localparam int unsigned DivCntW  = $clog2(MagW + 1);

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [ValueW-1:0] value;
  } knot_t;

  typedef enum logic [ActionW-1:0] {
    ActClear     = 3'd0,
    ActAdd       = 3'd1,
    ActSetSingle = 3'd2,
    ActQuery     = 3'd3,
    ActRead      = 3'd4
  } action_e;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StScan  = 7'b0000100,
    StMul   = 7'b0001000,
    StDivGo = 7'b0010000,
    StDiv   = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

endpackage

>>> design/brk_knot_mem.sv
module brk_knot_mem (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [brk_pkg::KnotAw-1:0] wr_addr_i,
  input  brk_pkg::knot_t             wr_data_i,
  input  logic                       rd_en_i,
  input  logic [brk_pkg::KnotAw-1:0] rd_addr_i,
  output brk_pkg::knot_t             rd_data_o
);
  import brk_pkg::*;

  knot_t mem_q [MaxKnots];
  knot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/brk_div.sv
module brk_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [brk_pkg::MagW-1:0] dividend_i,
  input  logic [brk_pkg::FrameW-1:0] divisor_i,
  output logic                     done_o,
  output logic [brk_pkg::MagW-1:0] quotient_o
);
  import brk_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [MagW-1:0]    dq_q;
  logic [FrameW-1:0]  rem_q;
  logic [FrameW-1:0]  den_q;
  logic [FrameW:0]    trial;
  logic [FrameW:0]    diff;
  logic               ge;

  assign trial = {rem_q, dq_q[MagW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = DivCntW'(MagW);
    end else if (busy_q) begin
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[FrameW-1:0] : trial[FrameW-1:0];
      dq_q  <= {dq_q[MagW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

>>> design/breakpoint_ramp_interpolator_top.sv
// Piecewise-linear envelope over a table of up to sixteen (frame, value) knots held in a
// single-port-read synchronous memory; values are signed Q16.16. One item is worked at a
// time and gives exactly one result. A query on a non-empty table scans it from its
// last knot downward, one knot per cycle through the memory read port; an interpolating
// query adds a multiply step and a bit-serial divider of 48 steps. Results wait in an
// output register.
`include "breakpoint_ramp_interpolator_top_assert.svh"

module breakpoint_ramp_interpolator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [brk_pkg::ActionW-1:0]   action_i,
  input  logic [brk_pkg::FrameW-1:0]    frame_i,
  input  logic signed [brk_pkg::ValueW-1:0] value_i,
  input  logic [brk_pkg::IndexW-1:0]    knot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [brk_pkg::ValueW-1:0] result_value_o,
  output logic [brk_pkg::FrameW-1:0]    result_frame_o,
  output logic                          accepted_o,
  output logic [brk_pkg::CountW-1:0]    knots_held_o,
  output logic [brk_pkg::RefusalW-1:0]  refusals_seen_o
);
  import brk_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   knot_total_q, knot_total_d;
  logic [RefusalW-1:0] refusal_total_q, refusal_total_d;
  logic [FrameW-1:0]   last_frame_q, last_frame_d;
  logic                out_valid_q, out_valid_d;

  logic [ValueW-1:0]   out_value_q;
  logic [FrameW-1:0]   out_frame_q;
  logic                out_acc_q;
  logic [CountW-1:0]   out_held_q;
  logic [RefusalW-1:0] out_refusals_q;
  logic                out_load;

  logic [ValueW-1:0]   res_value_q, res_value_d;
  logic [FrameW-1:0]   res_frame_q, res_frame_d;
  logic                res_acc_q, res_acc_d;
  logic [FrameW-1:0]   query_frame_q, query_frame_d;
  logic                read_ok_q, read_ok_d;
  logic [KnotAw-1:0]   scan_idx_q, scan_idx_d;
  logic                have_upper_q, have_upper_d;
  knot_t               upper_q, upper_d;
  logic [ValueW-1:0]   a_q, a_d;
  logic [FrameW-1:0]   dfr_q, dfr_d;
  logic signed [ValueW:0] dval_q, dval_d;
  logic [FrameW-1:0]   den_q, den_d;
  logic signed [ProdW-1:0] prod_q, prod_d;

  logic                mem_wr_en;
  logic [KnotAw-1:0]   mem_wr_addr;
  knot_t               mem_wr_data;
  logic                mem_rd_en;
  logic [KnotAw-1:0]   mem_rd_addr;
  knot_t               mem_rd_data;

  logic                div_start;
  logic                div_done;
  logic [MagW-1:0]     div_quotient;
  logic [ProdW-1:0]    prod_neg;
  logic [ValueW-1:0]   quo_signed;

  logic                in_accept;
  logic                table_full;
  logic [KnotAw-1:0]   last_idx;

  assign in_accept  = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign table_full = (knot_total_q >= CountW'(MaxKnots));
  assign last_idx   = KnotAw'(knot_total_q - CountW'(1));
  assign prod_neg   = ProdW'(0) - prod_q;
  assign quo_signed = prod_q[ProdW-1] ? (ValueW'(0) - div_quotient[ValueW-1:0])
                                      : div_quotient[ValueW-1:0];
  assign out_load   = (state_q == StEmit) && (!out_valid_q || !out_stall_i);

  brk_knot_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  brk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[ProdW-1] ? prod_neg[MagW-1:0] : prod_q[MagW-1:0]),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_comb begin
    state_d         = state_q;
    knot_total_d    = knot_total_q;
    refusal_total_d = refusal_total_q;
    last_frame_d    = last_frame_q;
    res_value_d     = res_value_q;
    res_frame_d     = res_frame_q;
    res_acc_d       = res_acc_q;
    query_frame_d   = query_frame_q;
    read_ok_d       = read_ok_q;
    scan_idx_d      = scan_idx_q;
    have_upper_d    = have_upper_q;
    upper_d         = upper_q;
    a_d             = a_q;
    dfr_d           = dfr_q;
    dval_d          = dval_q;
    den_d           = den_q;
    prod_d          = prod_q;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = '0;
    mem_wr_data     = '0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = '0;
    div_start       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          res_value_d   = '0;
          res_frame_d   = '0;
          res_acc_d     = 1'b0;
          query_frame_d = frame_i;
          state_d       = StEmit;
          unique case (action_i)
            ActClear: begin
              knot_total_d    = '0;
              refusal_total_d = '0;
            end
            ActAdd: begin
              if (table_full || (knot_total_q != '0 && frame_i < last_frame_q)) begin
                if (refusal_total_q != '1) begin
                  refusal_total_d = refusal_total_q + RefusalW'(1);
                end
              end else begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = knot_total_q[KnotAw-1:0];
                mem_wr_data  = {frame_i, value_i};
                knot_total_d = knot_total_q + CountW'(1);
                last_frame_d = frame_i;
                res_acc_d    = 1'b1;
              end
            end
            ActSetSingle: begin
              refusal_total_d = '0;
              knot_total_d    = CountW'(1);
              last_frame_d    = '0;
              mem_wr_en       = 1'b1;
              mem_wr_addr     = '0;
              mem_wr_data     = {FrameW'(0), value_i};
            end
            ActQuery: begin
              if (knot_total_q != '0) begin
                mem_rd_en    = 1'b1;
                mem_rd_addr  = last_idx;
                scan_idx_d   = last_idx;
                have_upper_d = 1'b0;
                state_d      = StScan;
              end
            end
            ActRead: begin
              read_ok_d   = IndexW'(knot_total_q) > knot_index_i;
              mem_rd_en   = 1'b1;
              mem_rd_addr = knot_index_i[KnotAw-1:0];
              state_d     = StRead;
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        if (read_ok_q) begin
          res_value_d = mem_rd_data.value;
          res_frame_d = mem_rd_data.frame;
        end
        state_d = StEmit;
      end
      StScan: begin
        if (mem_rd_data.frame <= query_frame_q) begin
          if (!have_upper_q) begin
            res_value_d = mem_rd_data.value;
            state_d     = StEmit;
          end else if (upper_q.frame <= mem_rd_data.frame) begin
            res_value_d = upper_q.value;
            state_d     = StEmit;
          end else begin
            a_d     = mem_rd_data.value;
            dfr_d   = query_frame_q - mem_rd_data.frame;
            dval_d  = $signed({upper_q.value[ValueW-1], upper_q.value})
                    - $signed({mem_rd_data.value[ValueW-1], mem_rd_data.value});
            den_d   = upper_q.frame - mem_rd_data.frame;
            state_d = StMul;
          end
        end else if (scan_idx_q == '0) begin
          res_value_d = mem_rd_data.value;
          state_d     = StEmit;
        end else begin
          upper_d      = mem_rd_data;
          have_upper_d = 1'b1;
          scan_idx_d   = scan_idx_q - KnotAw'(1);
          mem_rd_en    = 1'b1;
          mem_rd_addr  = scan_idx_q - KnotAw'(1);
        end
      end
      StMul: begin
        prod_d  = $signed({1'b0, dfr_q}) * dval_q;
        state_d = StDivGo;
      end
      StDivGo: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          res_value_d = a_q + quo_signed;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      knot_total_q    <= '0;
      refusal_total_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      knot_total_q    <= knot_total_d;
      refusal_total_q <= refusal_total_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_frame_q  <= last_frame_d;
    res_value_q   <= res_value_d;
    res_frame_q   <= res_frame_d;
    res_acc_q     <= res_acc_d;
    query_frame_q <= query_frame_d;
    read_ok_q     <= read_ok_d;
    scan_idx_q    <= scan_idx_d;
    have_upper_q  <= have_upper_d;
    upper_q       <= upper_d;
    a_q           <= a_d;
    dfr_q         <= dfr_d;
    dval_q        <= dval_d;
    den_q         <= den_d;
    prod_q        <= prod_d;
    if (out_load) begin
      out_value_q    <= res_value_q;
      out_frame_q    <= res_frame_q;
      out_acc_q      <= res_acc_q;
      out_held_q     <= knot_total_q;
      out_refusals_q <= refusal_total_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_value_o  = out_value_q;
  assign result_frame_o  = out_frame_q;
  assign accepted_o      = out_acc_q;
  assign knots_held_o    = out_held_q;
  assign refusals_seen_o = out_refusals_q;

  `BRK_ASSERT_NEVER(a_total_bound, knot_total_q > CountW'(MaxKnots), "knot count exceeds table size")
  `BRK_ASSERT(a_full_refuses, (in_accept && action_i == ActAdd && table_full) |=> (knot_total_q == CountW'(MaxKnots) && refusal_total_q != '0), "add to full table was not refused")
  `BRK_ASSERT_NEVER(a_scan_nonempty, state_q == StScan && knot_total_q == '0, "scan runs on an empty table")
  `BRK_ASSERT(a_div_start_ctx, (state_q == StDivGo) |-> (den_q != '0), "interpolation divisor is zero")

endmodule

>>> sim/breakpoint_ramp_interpolator_checker.sv
module breakpoint_ramp_interpolator_checker
  import brk_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [ActionW-1:0]       action_i,
  input  logic [FrameW-1:0]        frame_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [IndexW-1:0]        knot_index_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [ValueW-1:0] result_value_i,
  input  logic [FrameW-1:0]        result_frame_i,
  input  logic                     accepted_i,
  input  logic [CountW-1:0]        knots_held_i,
  input  logic [RefusalW-1:0]      refusals_seen_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam int unsigned RefusalMax = (1 << RefusalW) - 1;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [FrameW-1:0]        frame;
    logic                     accepted;
    logic [CountW-1:0]        held;
    logic [RefusalW-1:0]      refusals;
  } envelope_result_t;

  logic [FrameW-1:0]        frame_tab [MaxKnots];
  logic signed [ValueW-1:0] value_tab [MaxKnots];
  int unsigned              held_q = 0;
  int unsigned              refusals_q = 0;
  envelope_result_t         results_due [$];
  int unsigned              fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic void clear_knots();
    held_q = 0;
    refusals_q = 0;
  endfunction

  function automatic logic append_knot(logic [FrameW-1:0] f, logic signed [ValueW-1:0] v);
    if (held_q >= MaxKnots || (held_q > 0 && f < frame_tab[held_q-1])) begin
      if (refusals_q < RefusalMax) refusals_q++;
      return 1'b0;
    end
    frame_tab[held_q] = f;
    value_tab[held_q] = v;
    held_q++;
    return 1'b1;
  endfunction

  function automatic logic signed [ValueW-1:0] envelope_at(logic [FrameW-1:0] f);
    longint signed a, b, num, span;
    if (held_q == 0) return '0;
    for (int k = int'(held_q) - 1; k >= 0; k--) begin
      if (frame_tab[k] <= f) begin
        if (k + 1 >= int'(held_q)) return value_tab[k];
        if (frame_tab[k+1] <= frame_tab[k]) return value_tab[k+1];
        a = value_tab[k];
        b = value_tab[k+1];
        num = (longint'(f) - longint'(frame_tab[k])) * (b - a);
        span = longint'(frame_tab[k+1]) - longint'(frame_tab[k]);
        return ValueW'(a + num / span);
      end
    end
    return value_tab[0];
  endfunction

  function automatic envelope_result_t envelope_step(logic [ActionW-1:0] act,
      logic [FrameW-1:0] f, logic signed [ValueW-1:0] v, logic [IndexW-1:0] idx);
    envelope_result_t r;
    r.value = '0;
    r.frame = '0;
    r.accepted = 1'b0;
    case (act)
      ActClear: clear_knots();
      ActAdd: r.accepted = append_knot(f, v);
      ActSetSingle: begin
        clear_knots();
        void'(append_knot('0, v));
      end
      ActQuery: r.value = envelope_at(f);
      ActRead: begin
        if (idx < held_q) begin
          r.value = value_tab[idx];
          r.frame = frame_tab[idx];
        end
      end
      default: ;
    endcase
    r.held = CountW'(held_q);
    r.refusals = RefusalW'(refusals_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    envelope_result_t got, want;
    if (!rst_ni) begin
      clear_knots();
      results_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(envelope_step(action_i, frame_i, value_i, knot_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got.value = result_value_i;
        got.frame = result_frame_i;
        got.accepted = accepted_i;
        got.held = knots_held_i;
        got.refusals = refusals_seen_i;
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result transfer: value %0d frame %0d", got.value, got.frame);
          end
        end else begin
          want = results_due.pop_front();
          if (got.value !== want.value || got.frame !== want.frame ||
              got.accepted !== want.accepted || got.held !== want.held ||
              got.refusals !== want.refusals) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected value %0d frame %0d accepted %0b held %0d refusals %0d",
                       want.value, want.frame, want.accepted, want.held, want.refusals);
              $display("          actual   value %0d frame %0d accepted %0b held %0d refusals %0d",
                       got.value, got.frame, got.accepted, got.held, got.refusals);
            end
          end
        end
      end
    end
    pending_o = results_due.size();
    fail_count_o = fails;
  end

endmodule

>>> sim/breakpoint_ramp_interpolator_top_tb.sv
module breakpoint_ramp_interpolator_top_tb;
  import brk_pkg::*;

  localparam logic [ActionW-1:0] ActSpareFirst = 3'd5;
  localparam logic [ActionW-1:0] ActSpareLast  = 3'd7;
  localparam int unsigned RandomItems = 680;
  localparam int unsigned PhaseItems  = 136;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ActionW-1:0]       action_i;
  logic [FrameW-1:0]        frame_i;
  logic signed [ValueW-1:0] value_i;
  logic [IndexW-1:0]        knot_index_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ValueW-1:0] result_value_o;
  logic [FrameW-1:0]        result_frame_o;
  logic                     accepted_o;
  logic [CountW-1:0]        knots_held_o;
  logic [RefusalW-1:0]      refusals_seen_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned items_sent = 0;

  int unsigned idle_plan [5]  = '{0, 88, 0, 33, 0};
  int unsigned stall_plan [5] = '{0, 0, 88, 33, 0};

  breakpoint_ramp_interpolator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .frame_i         (frame_i),
    .value_i         (value_i),
    .knot_index_i    (knot_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_o  (result_value_o),
    .result_frame_o  (result_frame_o),
    .accepted_o      (accepted_o),
    .knots_held_o    (knots_held_o),
    .refusals_seen_o (refusals_seen_o)
  );

  breakpoint_ramp_interpolator_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .frame_i         (frame_i),
    .value_i         (value_i),
    .knot_index_i    (knot_index_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_i  (result_value_o),
    .result_frame_i  (result_frame_o),
    .accepted_i      (accepted_o),
    .knots_held_i    (knots_held_o),
    .refusals_seen_i (refusals_seen_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #32_000_000;
    $display("FAIL breakpoint_ramp_interpolator_top");
    $finish;
  end

  // The receiver counts a long hold-off itself once one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send(logic [ActionW-1:0] act, logic [FrameW-1:0] f, logic [ValueW-1:0] v,
                      logic [IndexW-1:0] idx);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    frame_i      <= f;
    value_i      <= v;
    knot_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? {1'b0, {(ValueW-1){1'b1}}} : {1'b1, {(ValueW-1){1'b0}}};
      1, 2: return ValueW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return $urandom;
    endcase
  endfunction

  task automatic run_episode();
    int base_f, cur_f, lo_f, hi_f, n_adds, n_probes;
    if ($urandom_range(4) < 3) begin
      send(ActClear, FrameW'($urandom), $urandom, IndexW'($urandom));
    end else begin
      send(ActSetSingle, FrameW'($urandom), pick_value(), IndexW'($urandom));
    end
    base_f = $urandom_range(3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 1000);
    cur_f = base_f;
    n_adds = $urandom_range(0, 18);
    for (int i = 0; i < n_adds; i++) begin
      case ($urandom_range(19))
        0, 1, 2: send(ActAdd, FrameW'(cur_f), pick_value(), IndexW'($urandom));
        3: send(ActAdd, FrameW'(cur_f > 0 ? cur_f - 1 - $urandom_range(0, 99) : 0),
                pick_value(), IndexW'($urandom));
        4: send(ActAdd, FrameW'($urandom), pick_value(), IndexW'($urandom));
        default: begin
          cur_f = cur_f + $urandom_range(1, 2000);
          if (cur_f > 65535) cur_f = 65535;
          send(ActAdd, FrameW'(cur_f), pick_value(), IndexW'($urandom));
        end
      endcase
    end
    lo_f = base_f > 50 ? base_f - 50 : 0;
    hi_f = cur_f < 65485 ? cur_f + 50 : 65535;
    n_probes = $urandom_range(2, 10);
    for (int i = 0; i < n_probes; i++) begin
      case ($urandom_range(19))
        0: send(ActionW'($urandom_range(ActSpareLast, ActClear)), FrameW'($urandom),
                $urandom, IndexW'($urandom));
        1, 2: send(ActQuery, FrameW'($urandom), $urandom, IndexW'($urandom));
        3, 4, 5: send(ActRead, FrameW'($urandom), $urandom, IndexW'($urandom_range(0, 17)));
        6: send(ActRead, FrameW'($urandom), $urandom, IndexW'($urandom));
        default: send(ActQuery, FrameW'($urandom_range(lo_f, hi_f)), $urandom,
                      IndexW'($urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned random_base, phase;
    bit pressed;
    pressed      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ActClear;
    frame_i      = '0;
    value_i      = '0;
    knot_index_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(ActQuery, 16'd100, 32'd0, 8'd0);
    send(ActRead, 16'd0, 32'd0, 8'd0);
    send(ActAdd, 16'd100, {1'b0, {(ValueW-1){1'b1}}}, 8'd0);
    send(ActAdd, 16'd50, 32'd12345, 8'd0);
    send(ActAdd, 16'd100, {1'b1, {(ValueW-1){1'b0}}}, 8'd0);
    send(ActAdd, 16'd300, 32'h0001_0000, 8'd0);
    send(ActQuery, 16'd0, 32'd0, 8'd0);
    send(ActQuery, 16'd100, 32'd0, 8'd0);
    send(ActQuery, 16'd201, 32'd0, 8'd0);
    send(ActQuery, 16'd300, 32'd0, 8'd0);
    send(ActAdd, 16'hFFFF, 32'hFFFF_FFFF, 8'd0);
    send(ActQuery, 16'hFFFE, 32'd0, 8'd0);
    send(ActQuery, 16'd40000, 32'd0, 8'd0);
    send(ActRead, 16'd0, 32'd0, 8'd3);
    send(ActRead, 16'd0, 32'd0, 8'd4);
    send(ActRead, 16'd0, 32'd0, 8'hFF);
    for (int a = ActSpareFirst; a <= ActSpareLast; a++) begin
      send(ActionW'(a), FrameW'($urandom), $urandom, IndexW'($urandom));
    end
    send(ActSetSingle, 16'hFFFF, 32'h8000_0001, 8'd0);
    send(ActRead, 16'd0, 32'd0, 8'd0);
    send(ActQuery, 16'hFFFF, 32'd0, 8'd0);
    send(ActClear, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);

    // Fill the table, then offer adds that the full table must refuse.
    send(ActSetSingle, 16'd0, pick_value(), 8'd0);
    for (int i = 1; i < MaxKnots; i++) begin
      send(ActAdd, FrameW'(i * 4096), pick_value(), 8'd0);
    end
    send(ActQuery, 16'd30000, 32'd0, 8'd0);
    send(ActRead, 16'd0, 32'd0, IndexW'(MaxKnots - 1));
    for (int i = 0; i < 20; i++) begin
      send(ActAdd, FrameW'($urandom), $urandom, IndexW'($urandom));
    end
    send(ActQuery, 16'd5000, 32'd0, 8'd0);
    send(ActClear, 16'd0, 32'd0, 8'd0);
    send(ActAdd, 16'd7, 32'd7, 8'd0);

    random_base = items_sent;
    while (items_sent - random_base < RandomItems) begin
      phase = (items_sent - random_base) / PhaseItems;
      if (phase > 4) phase = 4;
      idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      if (phase == 4 && !pressed) begin
        pressed = 1'b1;
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) begin
          send(ActQuery, FrameW'($urandom), $urandom, IndexW'($urandom));
        end
      end
      run_episode();
    end

    in_valid_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 20000 && pending != 0; i++) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS breakpoint_ramp_interpolator_top");
    end else begin
      $display("FAIL breakpoint_ramp_interpolator_top");
    end
    $finish;
  end

endmodule
